// ----- design/vfspwm_pkg.sv -----
// Shared types and constants for the V/f three-phase sine PWM core.
package vfspwm_pkg;

    localparam int FREQ_W     = 16;
    localparam int VOL_W      = 17;
    localparam int OUT_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int LANE_W     = 3;

    localparam logic [CFG_IDX_W-1:0] REG_FREQ_LIMIT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MOD_LIMIT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FREQ_DEADBAND = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MOD_DEADBAND  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_GAIN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_CEILING  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD    = 3'd6;

    localparam logic [14:0] FREQ_LIMIT_RST    = 15'd12800;
    localparam logic [15:0] MOD_LIMIT_RST     = 16'd58982;
    localparam logic [14:0] FREQ_DEADBAND_RST = 15'd25;
    localparam logic [15:0] MOD_DEADBAND_RST  = 16'd65;
    localparam logic [31:0] PHASE_GAIN_RST    = 32'd68719477;
    localparam logic [15:0] DUTY_CEILING_RST  = 16'd58982;
    localparam logic [15:0] PWM_PERIOD_RST    = 16'd4200;

    localparam logic [63:0]        HALF_PI_Q30    = 64'd1686629713;
    localparam logic signed [16:0] SQRT3_HALF_Q16 = 17'sd56756;

    localparam logic [LANE_W-1:0] LANE_FIRST_OUT = 3'd3;
    localparam logic [LANE_W-1:0] LANE_LAST      = 3'd5;

    typedef struct packed {
        logic              load_in;
        logic              phase_clr;
        logic              clamp;
        logic              inc;
        logic              phase_step;
        logic              rd_b;
        logic              trig;
        logic              cos_mul;
        logic              wave;
        logic              lane_step;
        logic [LANE_W-1:0] lane;
        logic              publish;
    } dp_cmd_t;

    typedef struct packed {
        logic neutral;
    } dp_sts_t;

endpackage

// ----- design/vfspwm_dp.sv -----
// Datapath: config registers, clamps, phase accumulator, sine ROM, duty and compare math.
module vfspwm_dp #(
    parameter int PHASE_BITS      = 32,
    parameter int SINE_TABLE_BITS = 10,
    parameter int DUTY_FRAC_BITS  = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wen,
    input  logic [vfspwm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [vfspwm_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic signed [vfspwm_pkg::FREQ_W-1:0]  target_freq,
    input  logic signed [vfspwm_pkg::VOL_W-1:0]   target_vol,
    input  vfspwm_pkg::dp_cmd_t                   dp_cmd,
    output vfspwm_pkg::dp_sts_t                   dp_sts,
    output logic [vfspwm_pkg::OUT_W-1:0]          duty_u,
    output logic [vfspwm_pkg::OUT_W-1:0]          duty_v,
    output logic [vfspwm_pkg::OUT_W-1:0]          duty_w,
    output logic [vfspwm_pkg::OUT_W-1:0]          cmp_u,
    output logic [vfspwm_pkg::OUT_W-1:0]          cmp_v,
    output logic [vfspwm_pkg::OUT_W-1:0]          cmp_w,
    output logic                                  held_neutral
);
    import vfspwm_pkg::*;

    localparam int P          = PHASE_BITS;
    localparam int B          = SINE_TABLE_BITS;
    localparam int D          = DUTY_FRAC_BITS;
    localparam int TBL_N      = 1 << B;
    localparam int INC_SHIFT  = 48 - P;
    localparam int DUTY_SHIFT = 49 - D;
    localparam int WAVE_W     = 35;
    localparam int PROD_W     = 52;
    localparam int DUTY_W     = D + 1;

    typedef logic [16:0] sine_rom_t [0:TBL_N];

    function automatic logic [16:0] sine_entry(input int unsigned k);
        logic [63:0]        y;
        logic [63:0]        y2;
        logic [63:0]        term;
        logic [63:0]        t;
        logic signed [63:0] sum;
        logic [63:0]        v;
        y    = (HALF_PI_Q30 * 64'(k)) >> B;
        y2   = (y * y) >> 30;
        term = y;
        sum  = $signed(y);
        for (int n = 1; n <= 6; n++) begin
            t = (term * y2) >> 30;
            case (n)
                1:       term = t / 64'd6;
                2:       term = t / 64'd20;
                3:       term = t / 64'd42;
                4:       term = t / 64'd72;
                5:       term = t / 64'd110;
                default: term = t / 64'd156;
            endcase
            if (n % 2 == 1) begin
                sum = sum - $signed(term);
            end
            else begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0) begin
            sum = '0;
        end
        v = ($unsigned(sum) + 64'd8192) >> 14;
        if (v > 64'd65536) begin
            v = 64'd65536;
        end
        return v[16:0];
    endfunction

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t r;
        for (int k = 0; k <= TBL_N; k++) begin
            r[k] = sine_entry(k);
        end
        return r;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

    localparam logic signed [PROD_W:0] DUTY_BIAS = (PROD_W + 1)'(1) <<< 48;
    localparam logic [DUTY_W-1:0]      DUTY_HALF = DUTY_W'(1) << (D - 1);

    // configuration
    logic [14:0] freq_limit_reg;
    logic [15:0] mod_limit_reg;
    logic [14:0] freq_deadband_reg;
    logic [15:0] mod_deadband_reg;
    logic [31:0] phase_gain_reg;
    logic [15:0] duty_ceiling_reg;
    logic [15:0] pwm_period_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            freq_limit_reg    <= FREQ_LIMIT_RST;
            mod_limit_reg     <= MOD_LIMIT_RST;
            freq_deadband_reg <= FREQ_DEADBAND_RST;
            mod_deadband_reg  <= MOD_DEADBAND_RST;
            phase_gain_reg    <= PHASE_GAIN_RST;
            duty_ceiling_reg  <= DUTY_CEILING_RST;
            pwm_period_reg    <= PWM_PERIOD_RST;
        end
        else if (cfg_wen) begin
            case (cfg_index)
                REG_FREQ_LIMIT:    freq_limit_reg    <= cfg_data[14:0];
                REG_MOD_LIMIT:     mod_limit_reg     <= cfg_data[15:0];
                REG_FREQ_DEADBAND: freq_deadband_reg <= cfg_data[14:0];
                REG_MOD_DEADBAND:  mod_deadband_reg  <= cfg_data[15:0];
                REG_PHASE_GAIN:    phase_gain_reg    <= cfg_data[31:0];
                REG_DUTY_CEILING:  duty_ceiling_reg  <= cfg_data[15:0];
                REG_PWM_PERIOD:    pwm_period_reg    <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // input capture and clamp
    logic signed [FREQ_W-1:0] freq_in_reg;
    logic signed [VOL_W-1:0]  vol_in_reg;
    logic [15:0]              freq_mag;
    logic [14:0]              af_next;
    logic [15:0]              m_next;
    logic                     neutral_next;
    logic [14:0]              af_reg;
    logic                     neg_reg;
    logic [15:0]              m_reg;
    logic                     neutral_reg;

    always_comb begin
        freq_mag = freq_in_reg[FREQ_W-1] ? 16'(-freq_in_reg) : 16'(freq_in_reg);
        af_next  = (freq_mag > {1'b0, freq_limit_reg}) ? freq_limit_reg : freq_mag[14:0];
        if (vol_in_reg[VOL_W-1]) begin
            m_next = '0;
        end
        else if (vol_in_reg[15:0] > mod_limit_reg) begin
            m_next = mod_limit_reg;
        end
        else begin
            m_next = vol_in_reg[15:0];
        end
        neutral_next = (af_next <= freq_deadband_reg) || (m_next <= mod_deadband_reg);
    end

    always_ff @(posedge clk) begin
        if (dp_cmd.load_in) begin
            freq_in_reg <= target_freq;
            vol_in_reg  <= target_vol;
        end
        if (dp_cmd.clamp) begin
            af_reg  <= af_next;
            neg_reg <= freq_in_reg[FREQ_W-1];
            m_reg   <= m_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            neutral_reg <= 1'b0;
        end
        else if (dp_cmd.clamp) begin
            neutral_reg <= neutral_next;
        end
    end

    assign dp_sts.neutral = neutral_reg;

    // phase accumulator
    logic [46:0]  inc_prod;
    logic [P-1:0] inc_reg;
    logic [P-1:0] phase_acc_reg;
    logic [P-1:0] phase_acc_next;

    assign inc_prod = af_reg * phase_gain_reg;

    always_ff @(posedge clk) begin
        if (dp_cmd.inc) begin
            inc_reg <= P'(inc_prod >> INC_SHIFT);
        end
    end

    always_comb begin
        phase_acc_next = phase_acc_reg;
        if (dp_cmd.phase_clr) begin
            phase_acc_next = '0;
        end
        else if (dp_cmd.phase_step) begin
            phase_acc_next = neg_reg ? (phase_acc_reg - inc_reg) : (phase_acc_reg + inc_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            phase_acc_reg <= '0;
        end
        else begin
            phase_acc_reg <= phase_acc_next;
        end
    end

    // sine ROM, one read per cycle
    logic [1:0]   quad;
    logic [B-1:0] idx;
    logic [B:0]   rom_addr;
    logic [16:0]  rom_q_reg;
    logic [16:0]  tbl_a_reg;

    assign quad     = phase_acc_reg[P-1 -: 2];
    assign idx      = phase_acc_reg[P-3 -: B];
    assign rom_addr = dp_cmd.rd_b ? ((B + 1)'(TBL_N) - {1'b0, idx}) : {1'b0, idx};

    always_ff @(posedge clk) begin
        rom_q_reg <= SINE_ROM[rom_addr];
        if (dp_cmd.rd_b) begin
            tbl_a_reg <= rom_q_reg;
        end
    end

    // sin/cos and three waves
    logic signed [17:0]       tbl_a_s;
    logic signed [17:0]       tbl_b_s;
    logic signed [17:0]       sin_next;
    logic signed [17:0]       cos_next;
    logic signed [17:0]       sin_reg;
    logic signed [17:0]       cos_reg;
    logic signed [WAVE_W-1:0] cos_k_reg;
    logic signed [WAVE_W-1:0] sin_w;
    logic signed [WAVE_W-1:0] wave_reg [3];

    assign tbl_a_s = $signed({1'b0, tbl_a_reg});
    assign tbl_b_s = $signed({1'b0, rom_q_reg});

    always_comb begin
        case (quad)
            2'd0:    begin sin_next = tbl_a_s;  cos_next = tbl_b_s;  end
            2'd1:    begin sin_next = tbl_b_s;  cos_next = -tbl_a_s; end
            2'd2:    begin sin_next = -tbl_a_s; cos_next = -tbl_b_s; end
            default: begin sin_next = -tbl_b_s; cos_next = tbl_a_s;  end
        endcase
    end

    assign sin_w = WAVE_W'(sin_reg);

    always_ff @(posedge clk) begin
        if (dp_cmd.trig) begin
            sin_reg <= sin_next;
            cos_reg <= cos_next;
        end
        if (dp_cmd.cos_mul) begin
            cos_k_reg <= cos_reg * SQRT3_HALF_Q16;
        end
        if (dp_cmd.wave) begin
            wave_reg[0] <= sin_w <<< 16;
            wave_reg[1] <= -(sin_w <<< 15) - cos_k_reg;
            wave_reg[2] <= -(sin_w <<< 15) + cos_k_reg;
        end
    end

    // per-phase pipeline: modulate, duty, compare scale, write
    logic signed [WAVE_W-1:0] wave_sel;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W:0]   duty_total;
    logic [PROD_W:0]          duty_total_u;
    logic [DUTY_W-1:0]        duty_next;
    logic [DUTY_W-1:0]        duty_reg;
    logic [D+15:0]            ceil_wide;
    logic [DUTY_W-1:0]        ceil_d;
    logic [DUTY_W-1:0]        duty_clamped;
    logic [D+16:0]            cprod_reg;
    logic [D+16:0]            dq_wide;
    logic [OUT_W-1:0]         dq_next;
    logic [OUT_W-1:0]         dq_reg;
    logic [1:0]               wr_lane;
    logic [OUT_W-1:0]         lane_cmp_reg  [3];
    logic [OUT_W-1:0]         lane_duty_reg [3];

    always_comb begin
        case (dp_cmd.lane)
            3'd0:    wave_sel = wave_reg[0];
            3'd1:    wave_sel = wave_reg[1];
            3'd2:    wave_sel = wave_reg[2];
            default: wave_sel = '0;
        endcase
    end

    assign duty_total   = {prod_reg[PROD_W-1], prod_reg} + DUTY_BIAS;
    assign duty_total_u = duty_total[PROD_W] ? '0 : $unsigned(duty_total);
    assign duty_next    = neutral_reg ? DUTY_HALF : DUTY_W'(duty_total_u >> DUTY_SHIFT);

    assign ceil_wide    = {duty_ceiling_reg, {D{1'b0}}} >> 16;
    assign ceil_d       = DUTY_W'(ceil_wide);
    assign duty_clamped = (duty_reg > ceil_d) ? ceil_d : duty_reg;

    assign dq_wide = {duty_reg, 16'b0} >> D;
    assign dq_next = (|dq_wide[D+16:16]) ? {OUT_W{1'b1}} : dq_wide[15:0];

    assign wr_lane = 2'(dp_cmd.lane - LANE_FIRST_OUT);

    always_ff @(posedge clk) begin
        if (dp_cmd.lane_step) begin
            prod_reg  <= $signed({1'b0, m_reg}) * wave_sel;
            duty_reg  <= duty_next;
            cprod_reg <= duty_clamped * pwm_period_reg;
            dq_reg    <= dq_next;
            if (dp_cmd.lane >= LANE_FIRST_OUT) begin
                lane_cmp_reg[wr_lane]  <= cprod_reg[D+15:D];
                lane_duty_reg[wr_lane] <= dq_reg;
            end
        end
    end

    // result registers
    always_ff @(posedge clk) begin
        if (dp_cmd.publish) begin
            duty_u       <= lane_duty_reg[0];
            duty_v       <= lane_duty_reg[1];
            duty_w       <= lane_duty_reg[2];
            cmp_u        <= lane_cmp_reg[0];
            cmp_v        <= lane_cmp_reg[1];
            cmp_w        <= lane_cmp_reg[2];
            held_neutral <= neutral_reg;
        end
    end

endmodule

// ----- design/vfspwm_ctrl.sv -----
// Controller: sequences one tick through the datapath and owns both handshakes.
module vfspwm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                cmd,
    output logic                out_valid,
    input  logic                out_stall,
    output vfspwm_pkg::dp_cmd_t dp_cmd,
    input  vfspwm_pkg::dp_sts_t dp_sts
);
    import vfspwm_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CLAMP = 4'd1;
    localparam logic [3:0] ST_INC   = 4'd2;
    localparam logic [3:0] ST_PHASE = 4'd3;
    localparam logic [3:0] ST_RDA   = 4'd4;
    localparam logic [3:0] ST_RDB   = 4'd5;
    localparam logic [3:0] ST_TRIG  = 4'd6;
    localparam logic [3:0] ST_CMUL  = 4'd7;
    localparam logic [3:0] ST_WAVE  = 4'd8;
    localparam logic [3:0] ST_LANE  = 4'd9;
    localparam logic [3:0] ST_DONE  = 4'd10;

    logic [3:0]        state_reg;
    logic [3:0]        state_next;
    logic [LANE_W-1:0] lane_reg;
    logic [LANE_W-1:0] lane_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              in_take;
    logic              out_free;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign in_take   = in_valid && (state_reg == ST_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb begin
        state_next = state_reg;
        lane_next  = lane_reg;
        dp_cmd     = '0;
        dp_cmd.lane = lane_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_take) begin
                    if (cmd) begin
                        dp_cmd.phase_clr = 1'b1;
                    end
                    else begin
                        dp_cmd.load_in = 1'b1;
                        state_next     = ST_CLAMP;
                    end
                end
            end
            ST_CLAMP: begin
                dp_cmd.clamp = 1'b1;
                state_next   = ST_INC;
            end
            ST_INC: begin
                dp_cmd.inc = 1'b1;
                lane_next  = '0;
                state_next = dp_sts.neutral ? ST_LANE : ST_PHASE;
            end
            ST_PHASE: begin
                dp_cmd.phase_step = 1'b1;
                state_next        = ST_RDA;
            end
            ST_RDA: begin
                state_next = ST_RDB;
            end
            ST_RDB: begin
                dp_cmd.rd_b = 1'b1;
                state_next  = ST_TRIG;
            end
            ST_TRIG: begin
                dp_cmd.trig = 1'b1;
                state_next  = ST_CMUL;
            end
            ST_CMUL: begin
                dp_cmd.cos_mul = 1'b1;
                state_next     = ST_WAVE;
            end
            ST_WAVE: begin
                dp_cmd.wave = 1'b1;
                lane_next   = '0;
                state_next  = ST_LANE;
            end
            ST_LANE: begin
                dp_cmd.lane_step = 1'b1;
                if (lane_reg == LANE_LAST) begin
                    state_next = ST_DONE;
                end
                else begin
                    lane_next = lane_reg + 1'b1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    dp_cmd.publish = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (dp_cmd.publish) begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            lane_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            lane_reg      <= lane_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- design/vf_three_phase_sine_pwm_core.sv -----
// Top level of the open-loop V/f three-phase sine PWM core.
//
//   channel | handshake             | payload
//   --------+-----------------------+--------------------------------------------
//   in      | in_valid / in_stall   | cmd, target_freq, target_vol
//   out     | out_valid / out_stall | duty_u/v/w, cmp_u/v/w, held_neutral
//   cfg     | cfg_wen               | cfg_index, cfg_data
//
// One tick at a time: after acceptance the controller steps through clamp, increment multiply,
// phase add, two ROM reads, quadrant fold, cos scaling, waves, six lane steps and publish; when
// the deadband holds the output neutral it goes straight from the increment to the lane steps.
// A phase reset command clears the phase accumulator and produces no result transaction.
// in_stall stays high while a tick is in flight; a result held under out_stall lets the next
// tick run, which then waits in its last step until the output register frees.
// Reset loads the register defaults and zeroes the phase accumulator.
module vf_three_phase_sine_pwm_core #(
    parameter int PHASE_BITS      = 32,
    parameter int SINE_TABLE_BITS = 10,
    parameter int DUTY_FRAC_BITS  = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wen,
    input  logic [vfspwm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [vfspwm_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  cmd,
    input  logic signed [vfspwm_pkg::FREQ_W-1:0]  target_freq,
    input  logic signed [vfspwm_pkg::VOL_W-1:0]   target_vol,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [vfspwm_pkg::OUT_W-1:0]          duty_u,
    output logic [vfspwm_pkg::OUT_W-1:0]          duty_v,
    output logic [vfspwm_pkg::OUT_W-1:0]          duty_w,
    output logic [vfspwm_pkg::OUT_W-1:0]          cmp_u,
    output logic [vfspwm_pkg::OUT_W-1:0]          cmp_v,
    output logic [vfspwm_pkg::OUT_W-1:0]          cmp_w,
    output logic                                  held_neutral
);
    import vfspwm_pkg::*;

    dp_cmd_t dp_cmd;
    dp_sts_t dp_sts;

    vfspwm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .dp_cmd    (dp_cmd),
        .dp_sts    (dp_sts)
    );

    vfspwm_dp #(
        .PHASE_BITS      (PHASE_BITS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS),
        .DUTY_FRAC_BITS  (DUTY_FRAC_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wen      (cfg_wen),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .target_freq  (target_freq),
        .target_vol   (target_vol),
        .dp_cmd       (dp_cmd),
        .dp_sts       (dp_sts),
        .duty_u       (duty_u),
        .duty_v       (duty_v),
        .duty_w       (duty_w),
        .cmp_u        (cmp_u),
        .cmp_v        (cmp_v),
        .cmp_w        (cmp_w),
        .held_neutral (held_neutral)
    );

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for vf_three_phase_sine_pwm_core: directed table, then random ticks.
module tb;
    import vfspwm_pkg::*;

    localparam int SINE_BITS = 10;
    localparam int SINE_N = 1 << SINE_BITS;
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_PHASE_CLR = 1'b1;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 24;
    localparam int DIR_N = 22;

    typedef struct packed {
        logic [OUT_W-1:0] duty_u;
        logic [OUT_W-1:0] duty_v;
        logic [OUT_W-1:0] duty_w;
        logic [OUT_W-1:0] cmp_u;
        logic [OUT_W-1:0] cmp_v;
        logic [OUT_W-1:0] cmp_w;
        logic             neutral;
    } pwm_res_t;

    typedef struct packed {
        logic                     cmd;
        logic signed [FREQ_W-1:0] freq;
        logic signed [VOL_W-1:0]  vol;
        logic                     has_want;
        pwm_res_t                 want;
    } stim_row_t;

    // 50% on all phases under reset settings: 32768 * 4200 / 65536 = 2100
    localparam pwm_res_t NEUTRAL_AT_RESET =
        '{16'd32768, 16'd32768, 16'd32768, 16'd2100, 16'd2100, 16'd2100, 1'b1};

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_wen = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [CFG_DATA_W-1:0]      cfg_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic                       cmd = 1'b0;
    logic signed [FREQ_W-1:0]   target_freq = '0;
    logic signed [VOL_W-1:0]    target_vol = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [OUT_W-1:0]           duty_u;
    logic [OUT_W-1:0]           duty_v;
    logic [OUT_W-1:0]           duty_w;
    logic [OUT_W-1:0]           cmp_u;
    logic [OUT_W-1:0]           cmp_v;
    logic [OUT_W-1:0]           cmp_w;
    logic                       held_neutral;

    // shadow of the block's registers and phase
    int unsigned   sine_rom [SINE_N+1];
    logic [14:0]   lim_freq;
    logic [15:0]   lim_mod;
    logic [14:0]   db_freq;
    logic [15:0]   db_mod;
    logic [31:0]   gain_phase;
    logic [15:0]   ceil_duty;
    logic [15:0]   period_pwm;
    logic [31:0]   phase_pos;

    pwm_res_t      duty_backlog [$];
    pwm_res_t      head;
    int            mismatch_cnt = 0;
    int            cycle_cnt = 0;
    logic          tx_tight = 1'b0;
    int            rx_hold = 0;
    int            rx_calm = 0;
    int            rx_pick;

    stim_row_t dir_rows [DIR_N] = '{
        '{CMD_TICK, 16'sd0, 17'sd30000, 1'b1, NEUTRAL_AT_RESET},
        '{CMD_TICK, 16'sd25, 17'sd30000, 1'b1, NEUTRAL_AT_RESET},
        '{CMD_TICK, -16'sd25, 17'sd30000, 1'b1, NEUTRAL_AT_RESET},
        '{CMD_TICK, 16'sd26, 17'sd30000, 1'b0, '0},
        '{CMD_TICK, 16'sd1000, 17'sd65, 1'b1, NEUTRAL_AT_RESET},
        '{CMD_TICK, 16'sd1000, 17'sd66, 1'b0, '0},
        '{CMD_TICK, 16'sd1000, 17'h10000, 1'b1, NEUTRAL_AT_RESET},
        '{CMD_TICK, -16'sd1000, 17'h1FFFF, 1'b1, NEUTRAL_AT_RESET},
        '{CMD_TICK, 16'sd32767, 17'sd65535, 1'b0, '0},
        '{CMD_TICK, 16'h8000, 17'sd65535, 1'b0, '0},
        '{CMD_TICK, 16'h8000, 17'h10000, 1'b1, NEUTRAL_AT_RESET},
        '{CMD_PHASE_CLR, 16'hFFFF, 17'h1FFFF, 1'b0, '0},
        '{CMD_TICK, -16'sd26, 17'sd30000, 1'b0, '0},
        '{CMD_PHASE_CLR, 16'sd0, 17'sd0, 1'b0, '0},
        '{CMD_TICK, 16'sd12800, 17'sd58982, 1'b0, '0},
        '{CMD_TICK, 16'sd12800, 17'sd65535, 1'b0, '0},
        '{CMD_TICK, 16'sd12800, 17'sd65535, 1'b0, '0},
        '{CMD_TICK, 16'sd12799, 17'sd1, 1'b1, NEUTRAL_AT_RESET},
        '{CMD_TICK, 16'sd12801, 17'sd65535, 1'b0, '0},
        '{CMD_TICK, -16'sd12801, 17'sd40000, 1'b0, '0},
        '{CMD_TICK, 16'h5555, 17'h0AAAA, 1'b0, '0},
        '{CMD_TICK, 16'hAAAA, 17'h15555, 1'b1, NEUTRAL_AT_RESET}
    };

    vf_three_phase_sine_pwm_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wen      (cfg_wen),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .target_freq  (target_freq),
        .target_vol   (target_vol),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .duty_u       (duty_u),
        .duty_v       (duty_v),
        .duty_w       (duty_w),
        .cmp_u        (cmp_u),
        .cmp_v        (cmp_v),
        .cmp_w        (cmp_w),
        .held_neutral (held_neutral)
    );

    always #5 clk = ~clk;

    function automatic void build_sine_rom();
        longint unsigned y, y2, term, v;
        longint          sum;
        for (int k = 0; k <= SINE_N; k++)
        begin
            y = (64'(HALF_PI_Q30) * 64'(k)) >> SINE_BITS;
            y2 = (y * y) >> 30;
            term = y;
            sum = longint'(y);
            for (int n = 1; n <= 6; n++)
            begin
                term = ((term * y2) >> 30) / 64'((2 * n) * (2 * n + 1));
                if (n % 2 == 1)
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            if (sum < 0)
                sum = 0;
            v = (64'(sum) + 64'd8192) >> 14;
            if (v > 64'd65536)
                v = 64'd65536;
            sine_rom[k] = 32'(v);
        end
    endfunction

    function automatic void shadow_write(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_FREQ_LIMIT:    lim_freq = data[14:0];
            REG_MOD_LIMIT:     lim_mod = data[15:0];
            REG_FREQ_DEADBAND: db_freq = data[14:0];
            REG_MOD_DEADBAND:  db_mod = data[15:0];
            REG_PHASE_GAIN:    gain_phase = data;
            REG_DUTY_CEILING:  ceil_duty = data[15:0];
            REG_PWM_PERIOD:    period_pwm = data[15:0];
            default:           ;
        endcase
    endfunction

    function automatic longint unsigned duty_of(input longint m, input longint wave);
        longint t;
        t = m * wave + (longint'(1) << 48);
        if (t < 0)
            t = 0;
        return 64'(t) >> 33;
    endfunction

    // {duty in Q0.16 saturated, compare count after ceiling}
    function automatic logic [31:0] to_outputs(input longint unsigned duty);
        longint unsigned lim, q;
        logic [15:0]     d16;
        lim = (duty > 64'(ceil_duty)) ? 64'(ceil_duty) : duty;
        q = (lim * 64'(period_pwm)) >> 16;
        d16 = (duty > 64'd65535) ? 16'hFFFF : duty[15:0];
        return {d16, q[15:0]};
    endfunction

    function automatic logic step_phase(input logic c, input logic signed [FREQ_W-1:0] fi,
                                        input logic signed [VOL_W-1:0] vi,
                                        output pwm_res_t r);
        longint          f, m, af, s, cs, wu, wv, ww;
        longint unsigned inc, du, dv, dw;
        logic [1:0]      quad;
        int              idx;
        r = '0;
        if (c == CMD_PHASE_CLR)
        begin
            phase_pos = '0;
            return 1'b0;
        end
        f = longint'(fi);
        m = longint'(vi);
        if (f > longint'(lim_freq))
            f = longint'(lim_freq);
        if (f < -longint'(lim_freq))
            f = -longint'(lim_freq);
        if (m < 0)
            m = 0;
        if (m > longint'(lim_mod))
            m = longint'(lim_mod);
        af = (f < 0) ? -f : f;
        r.neutral = (af <= longint'(db_freq)) || (m <= longint'(db_mod));
        if (r.neutral)
        begin
            du = 64'd32768;
            dv = du;
            dw = du;
        end
        else
        begin
            inc = (64'(af) * 64'(gain_phase)) >> 16;
            if (f < 0)
                phase_pos = phase_pos - inc[31:0];
            else
                phase_pos = phase_pos + inc[31:0];
            quad = phase_pos[31:30];
            idx = int'(phase_pos[29:20]);
            case (quad)
                2'd0:
                begin
                    s = longint'(sine_rom[idx]);
                    cs = longint'(sine_rom[SINE_N - idx]);
                end
                2'd1:
                begin
                    s = longint'(sine_rom[SINE_N - idx]);
                    cs = -longint'(sine_rom[idx]);
                end
                2'd2:
                begin
                    s = -longint'(sine_rom[idx]);
                    cs = -longint'(sine_rom[SINE_N - idx]);
                end
                default:
                begin
                    s = -longint'(sine_rom[SINE_N - idx]);
                    cs = longint'(sine_rom[idx]);
                end
            endcase
            wu = s * 65536;
            wv = -s * 32768 - cs * longint'(SQRT3_HALF_Q16);
            ww = -s * 32768 + cs * longint'(SQRT3_HALF_Q16);
            du = duty_of(m, wu);
            dv = duty_of(m, wv);
            dw = duty_of(m, ww);
        end
        {r.duty_u, r.cmp_u} = to_outputs(du);
        {r.duty_v, r.cmp_v} = to_outputs(dv);
        {r.duty_w, r.cmp_w} = to_outputs(dw);
        return 1'b1;
    endfunction

    function automatic int pick_gap();
        int p;
        if (tx_tight)
            return 0;
        p = $urandom_range(99);
        if (p < 55)
            return 0;
        if (p < 90)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    task automatic send_txn(input logic c, input logic signed [FREQ_W-1:0] f,
                            input logic signed [VOL_W-1:0] v,
                            input logic has_want, input pwm_res_t want);
        int       gap;
        pwm_res_t calc;
        gap = pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        target_freq <= f;
        target_vol <= v;
        do @(posedge clk); while (in_stall !== 1'b0);
        if (step_phase(c, f, v, calc))
            duty_backlog.push_back(has_want ? want : calc);
    endtask

    // phase clear leaves no result, so give the core time to finish after the last one
    task automatic settle();
        in_valid <= 1'b0;
        while (duty_backlog.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_regs(input logic [31:0] fl, input logic [31:0] ml,
                            input logic [31:0] fd, input logic [31:0] md,
                            input logic [31:0] pg, input logic [31:0] dc,
                            input logic [31:0] pp);
        logic [CFG_DATA_W-1:0] vals [7];
        logic [CFG_IDX_W-1:0]  ids [7];
        vals = '{fl, ml, fd, md, pg, dc, pp};
        ids = '{REG_FREQ_LIMIT, REG_MOD_LIMIT, REG_FREQ_DEADBAND, REG_MOD_DEADBAND,
                REG_PHASE_GAIN, REG_DUTY_CEILING, REG_PWM_PERIOD};
        for (int i = 0; i < 7; i++)
        begin
            cfg_wen <= 1'b1;
            cfg_index <= ids[i];
            cfg_data <= vals[i];
            @(posedge clk);
            shadow_write(ids[i], vals[i]);
        end
        // index past the register list: must be ignored
        cfg_index <= REG_NONE;
        cfg_data <= $urandom;
        @(posedge clk);
        cfg_wen <= 1'b0;
    endtask

    task automatic run_random(input int n_items);
        logic                     c;
        logic signed [FREQ_W-1:0] f;
        logic signed [VOL_W-1:0]  v;
        for (int i = 0; i < n_items; i++)
        begin
            if (i % 64 == 0)
                tx_tight = ($urandom_range(2) == 0);
            if ($urandom_range(99) == 0)
            begin
                in_valid <= 1'b0;
                do @(posedge clk); while (duty_backlog.size() != 0);
            end
            c = ($urandom_range(99) < 5) ? CMD_PHASE_CLR : CMD_TICK;
            f = FREQ_W'($urandom);
            v = VOL_W'($urandom);
            if ($urandom_range(9) < 7)
            begin
                if (lim_freq > db_freq)
                begin
                    f = FREQ_W'($urandom_range(lim_freq, db_freq + 1));
                    if ($urandom_range(1) == 1)
                        f = -f;
                end
                if (lim_mod > db_mod)
                    v = VOL_W'($urandom_range(lim_mod, db_mod + 1));
            end
            send_txn(c, f, v, 1'b0, '0);
        end
    endtask

    task automatic check_field(input string nm, input logic [OUT_W-1:0] want,
                               input logic [OUT_W-1:0] got);
        if (got !== want)
        begin
            mismatch_cnt++;
            $display("%0t: %s expected %0d, actual %0d", $time, nm, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        if (rx_calm != 0)
        begin
            rx_calm <= rx_calm - 1;
            out_stall <= 1'b0;
        end
        else if (rx_hold != 0)
            rx_hold <= rx_hold - 1;
        else
        begin
            rx_pick = $urandom_range(99);
            if (rx_pick < 3)
            begin
                rx_calm <= $urandom_range(400, 100);
                out_stall <= 1'b0;
            end
            else if (rx_pick < 55)
                out_stall <= 1'b0;
            else if (rx_pick < 93)
            begin
                out_stall <= 1'b1;
                rx_hold <= $urandom_range(3, 0);
            end
            else
            begin
                out_stall <= 1'b1;
                rx_hold <= $urandom_range(40, 10);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
        begin
            if (duty_backlog.size() == 0)
            begin
                mismatch_cnt++;
                $display("%0t: result transaction expected none, actual duty_u %0d",
                         $time, duty_u);
            end
            else
            begin
                head = duty_backlog.pop_front();
                check_field("duty_u", head.duty_u, duty_u);
                check_field("duty_v", head.duty_v, duty_v);
                check_field("duty_w", head.duty_w, duty_w);
                check_field("cmp_u", head.cmp_u, cmp_u);
                check_field("cmp_v", head.cmp_v, cmp_v);
                check_field("cmp_w", head.cmp_w, cmp_w);
                check_field("held_neutral", 16'(head.neutral), 16'(held_neutral));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        build_sine_rom();
        lim_freq = FREQ_LIMIT_RST;
        lim_mod = MOD_LIMIT_RST;
        db_freq = FREQ_DEADBAND_RST;
        db_mod = MOD_DEADBAND_RST;
        gain_phase = PHASE_GAIN_RST;
        ceil_duty = DUTY_CEILING_RST;
        period_pwm = PWM_PERIOD_RST;
        phase_pos = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_N; i++)
            send_txn(dir_rows[i].cmd, dir_rows[i].freq, dir_rows[i].vol,
                     dir_rows[i].has_want, dir_rows[i].want);
        run_random(250);
        settle();

        set_regs(32767, 65535, 0, 0, 32'hFFFF_FFFF, 65535, 65535);
        run_random(250);
        settle();

        // phase frozen, duty ceiling of zero on the compare path, zero period
        set_regs(9000, 65535, 0, 0, 0, 0, 0);
        run_random(150);
        settle();

        // upper data bits must be dropped; everything lands in the deadband
        set_regs(32'hFFFF_8000, 32'hFFFF_0000, 32767, 65535, 32'h1234_5678, 20000, 1);
        run_random(80);
        settle();

        set_regs(5000, 40000, 300, 3000, 32'h9E37_79B9, 30000, 65535);
        run_random(250);
        settle();

        set_regs($urandom_range(32767), $urandom_range(65535), $urandom_range(400),
                 $urandom_range(2000), $urandom, $urandom, $urandom_range(65535, 1));
        run_random(250);
        settle();

        set_regs(FREQ_LIMIT_RST, MOD_LIMIT_RST, FREQ_DEADBAND_RST, MOD_DEADBAND_RST,
                 PHASE_GAIN_RST, DUTY_CEILING_RST, PWM_PERIOD_RST);
        run_random(250);
        settle();

        if (mismatch_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
